>>> rtl/nues_pkg.sv
package nues_pkg;

	localparam int unsigned LEN_OUT_W = 16;

	localparam logic [7:0] STOP_BYTE    = 8'h80;
	localparam logic [7:0] HDR_MASK     = 8'hC1;
	localparam logic [7:0] HDR_MATCH    = 8'h41;
	localparam logic [7:0] RSVD_BYTE    = 8'hFF;
	localparam logic [7:0] TYPE_MASK    = 8'h3E;
	localparam logic [4:0] TYPE_NON_IDR = 5'd28;
	localparam logic [4:0] TYPE_IDR     = 5'd29;
	localparam logic [7:0] EPB_BYTE     = 8'h03;
	localparam logic [7:0] SC_ONE       = 8'h01;

	typedef enum logic [2:0] {
		ST_OK        = 3'd0,
		ST_NO_STOP   = 3'd1,
		ST_BAD_START = 3'd2,
		ST_BAD_BITS  = 3'd3,
		ST_BAD_TYPE  = 3'd4,
		ST_SHORT     = 3'd5
	} status_t;

	typedef enum logic [7:0] {
		PH_SC0  = 8'b0000_0001,
		PH_SC1  = 8'b0000_0010,
		PH_SC2  = 8'b0000_0100,
		PH_SC3  = 8'b0000_1000,
		PH_HDR0 = 8'b0001_0000,
		PH_HDR1 = 8'b0010_0000,
		PH_BODY = 8'b0100_0000,
		PH_SINK = 8'b1000_0000
	} phase_t;

	typedef struct packed {
		logic                 fire;
		logic [7:0]           out_byte;
		logic                 out_valid;
		logic                 unit_done;
		status_t              status;
		logic                 is_idr;
		logic [LEN_OUT_W-1:0] payload_length;
	} result_t;

endpackage

>>> rtl/nal_unit_emulation_strip.sv
// NAL unit unwrapper with emulation prevention byte removal.
// Input channel: in_valid / in_stall carry one word per cycle, a byte of the
// encapsulated unit (in_byte) with end_of_unit high on the final byte.
// Result channel: res_valid / res_stall carry one result word: a payload byte
// (out_byte, out_valid) and, on the final byte, the unit report (unit_done,
// status, is_idr, payload_length). Bytes that produce nothing (start code,
// header, dropped 0x03, bytes after an error) give no result word.
// Throughput: one input word per clock unless a blocked result stalls it;
// the byte's parser state update is combinational logic between the input
// and result regs. An accepted word waits in the input register until it
// advances, and its result, if any, loads the result register. Payload
// bytes trail the input by one byte; the last one leaves with the unit report.
// Stall: while res_stall holds a result, a byte that would produce a result
// waits in the input register and in_stall rises; bytes that produce no
// result still advance. Reset returns the parser to the first start code
// byte and empties both registers.
module nal_unit_emulation_strip #(
	parameter int unsigned LENGTH_BITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  in_byte,
	input  logic        end_of_unit,
	output logic        res_valid,
	input  logic        res_stall,
	output logic [7:0]  out_byte,
	output logic        out_valid,
	output logic        unit_done,
	output logic [2:0]  status,
	output logic        is_idr,
	output logic [nues_pkg::LEN_OUT_W-1:0] payload_length
);
	import nues_pkg::*;

	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       last_s1;
	logic       advance;
	logic       accept;
	logic       res_valid_q;
	result_t    res_d;
	result_t    res_q;

	// advance the held word unless it has a result and the output is blocked
	assign advance  = valid_s1 && (!res_d.fire || !res_valid_q || !res_stall);
	assign in_stall = valid_s1 && !advance;
	assign accept   = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			byte_s1 <= in_byte;
			last_s1 <= end_of_unit;
		end
	end

	nues_step #(
		.LENGTH_BITS(LENGTH_BITS)
	) u_step (
		.clk        (clk),
		.arst_n     (arst_n),
		.step_en    (advance),
		.in_byte    (byte_s1),
		.end_of_unit(last_s1),
		.res        (res_d)
	);

	// result register: load a new word, or drop the old one once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (advance && res_d.fire) begin
			res_valid_q <= 1'b1;
		end else if (!res_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && res_d.fire)
			res_q <= res_d;
	end

	assign res_valid      = res_valid_q;
	assign out_byte       = res_q.out_byte;
	assign out_valid      = res_q.out_valid;
	assign unit_done      = res_q.unit_done;
	assign status         = res_q.status;
	assign is_idr         = res_q.is_idr;
	assign payload_length = res_q.payload_length;

	a_word_has_content: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> (out_valid || unit_done))
		else $error("result word carries neither payload nor report");

	a_report_only_at_end: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && !unit_done) |-> (status == ST_OK && payload_length == '0 && !is_idr))
		else $error("report fields set on a mid-unit word");

	a_status_range: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && unit_done) |-> (status <= ST_SHORT))
		else $error("status code out of range");

	a_stall_needs_word: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (valid_s1 && res_valid_q && res_stall))
		else $error("input stalled without a blocked result");

	a_blocked_result_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid_q && res_stall) |=> (res_valid_q && $stable(res_q)))
		else $error("blocked result register changed");

endmodule

>>> rtl/nues_step.sv
module nues_step #(
	parameter int unsigned LENGTH_BITS = 16
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             step_en,
	input  logic [7:0]       in_byte,
	input  logic             end_of_unit,
	output nues_pkg::result_t res
);
	import nues_pkg::*;

	phase_t                 phase_q, phase_d;
	logic [1:0]             zero_run_q, zero_run_d;
	logic [7:0]             held_byte_q, held_byte_d;
	logic                   held_valid_q, held_valid_d;
	status_t                error_q, error_d;
	logic                   idr_q, idr_d;
	logic [LENGTH_BITS-1:0] count_q, count_d, count_inc;
	logic [31:0]            count_ext;
	logic [4:0]             nal_type;

	assign nal_type  = 5'((held_byte_q & TYPE_MASK) >> 1);
	assign count_inc = (count_q != {LENGTH_BITS{1'b1}}) ? count_q + 1'b1 : count_q;

	always_comb begin
		phase_d      = phase_q;
		zero_run_d   = zero_run_q;
		held_byte_d  = held_byte_q;
		held_valid_d = held_valid_q;
		error_d      = error_q;
		idr_d        = idr_q;
		count_d      = count_q;
		res          = '0;
		res.status   = ST_OK;

		if (!end_of_unit) begin
			unique case (phase_q)
				PH_SC0, PH_SC1: begin
					if (in_byte != 8'h00) begin
						error_d = ST_BAD_START;
						phase_d = PH_SINK;
					end else begin
						phase_d = (phase_q == PH_SC0) ? PH_SC1 : PH_SC2;
					end
				end
				PH_SC2: begin
					if (in_byte == SC_ONE) begin
						phase_d = PH_HDR0;
					end else if (in_byte == 8'h00) begin
						phase_d = PH_SC3;
					end else begin
						error_d = ST_BAD_START;
						phase_d = PH_SINK;
					end
				end
				PH_SC3: begin
					if (in_byte == SC_ONE) begin
						phase_d = PH_HDR0;
					end else begin
						error_d = ST_BAD_START;
						phase_d = PH_SINK;
					end
				end
				PH_HDR0: begin
					held_byte_d = in_byte;
					phase_d     = PH_HDR1;
				end
				PH_HDR1: begin
					if ((held_byte_q & HDR_MASK) != HDR_MATCH || in_byte != RSVD_BYTE) begin
						error_d = ST_BAD_BITS;
						phase_d = PH_SINK;
					end else if (nal_type != TYPE_NON_IDR && nal_type != TYPE_IDR) begin
						error_d = ST_BAD_TYPE;
						phase_d = PH_SINK;
					end else begin
						idr_d        = (nal_type == TYPE_IDR);
						held_byte_d  = 8'h00;
						held_valid_d = 1'b0;
						zero_run_d   = 2'd0;
						phase_d      = PH_BODY;
					end
				end
				PH_BODY: begin
					if (zero_run_q == 2'd2 && in_byte == EPB_BYTE) begin
						// drop the emulation prevention byte
						zero_run_d = 2'd0;
					end else begin
						if (in_byte == 8'h00)
							zero_run_d = (zero_run_q != 2'd3) ? zero_run_q + 2'd1 : 2'd3;
						else
							zero_run_d = 2'd0;
						if (held_valid_q) begin
							res.fire      = 1'b1;
							res.out_valid = 1'b1;
							res.out_byte  = held_byte_q;
							count_d       = count_inc;
						end
						held_byte_d  = in_byte;
						held_valid_d = 1'b1;
					end
				end
				PH_SINK: begin
				end
				default: begin
				end
			endcase
		end else begin
			res.fire      = 1'b1;
			res.unit_done = 1'b1;
			res.is_idr    = idr_q;
			if (phase_q == PH_SINK) begin
				res.status = (in_byte != STOP_BYTE) ? ST_NO_STOP : error_q;
			end else if (phase_q == PH_BODY) begin
				if (held_valid_q) begin
					res.out_valid = 1'b1;
					res.out_byte  = held_byte_q;
					count_d       = count_inc;
				end
				res.status = (in_byte != STOP_BYTE) ? ST_NO_STOP : ST_OK;
			end else begin
				res.status = ST_SHORT;
			end
			// back to the reset state for the next unit
			phase_d      = PH_SC0;
			zero_run_d   = 2'd0;
			held_byte_d  = 8'h00;
			held_valid_d = 1'b0;
			error_d      = ST_OK;
			idr_d        = 1'b0;
		end
		if (end_of_unit)
			res.payload_length = count_ext[LEN_OUT_W-1:0];
	end

	assign count_ext = 32'(count_d);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= PH_SC0;
			zero_run_q   <= 2'd0;
			held_byte_q  <= 8'h00;
			held_valid_q <= 1'b0;
			error_q      <= ST_OK;
			idr_q        <= 1'b0;
			count_q      <= '0;
		end else if (step_en) begin
			phase_q      <= phase_d;
			zero_run_q   <= zero_run_d;
			held_byte_q  <= held_byte_d;
			held_valid_q <= held_valid_d;
			error_q      <= error_d;
			idr_q        <= idr_d;
			count_q      <= end_of_unit ? '0 : count_d;
		end
	end

endmodule

>>> sim/nal_unit_emulation_strip_check.sv
`timescale 1ns / 100ps

module nal_unit_emulation_strip_check (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	input  logic                           in_stall,
	input  logic [7:0]                     in_byte,
	input  logic                           end_of_unit,
	input  logic                           res_valid,
	input  logic                           res_stall,
	input  logic [7:0]                     out_byte,
	input  logic                           out_valid,
	input  logic                           unit_done,
	input  logic [2:0]                     status,
	input  logic                           is_idr,
	input  logic [nues_pkg::LEN_OUT_W-1:0] payload_length,
	output int                             mismatches,
	output int                             outstanding
);
	import nues_pkg::*;

	localparam int unsigned     LENGTH_BITS = 16;
	localparam longint unsigned LEN_MAX     = (64'd1 << LENGTH_BITS) - 64'd1;

	typedef struct packed {
		logic [7:0]           data;
		logic                 data_ok;
		logic                 done;
		status_t              st;
		logic                 idr;
		logic [LEN_OUT_W-1:0] len;
	} strip_word_t;

	strip_word_t     expected_words[$];

	phase_t          parse_phase;
	logic [1:0]      zero_run;
	logic [7:0]      held;
	logic            held_ok;
	status_t         err_code;
	logic            idr;
	longint unsigned emitted;

	function automatic void clear_parser();
		parse_phase = PH_SC0;
		zero_run    = 2'd0;
		held        = 8'h00;
		held_ok     = 1'b0;
		err_code    = ST_OK;
		idr         = 1'b0;
		emitted     = 0;
	endfunction

	function automatic void mark_error(status_t code);
		err_code    = code;
		parse_phase = PH_SINK;
	endfunction

	function automatic void count_payload();
		if (emitted < LEN_MAX)
			emitted++;
	endfunction

	// Advance the parser by one byte and queue the word it should produce, if any.
	function automatic void predict_unwrap(logic [7:0] b, logic last);
		strip_word_t w;
		logic [4:0]  nal_type;
		w = '0;
		if (!last) begin
			case (parse_phase)
			PH_SC0: begin
				if (b != 8'h00) mark_error(ST_BAD_START);
				else parse_phase = PH_SC1;
			end
			PH_SC1: begin
				if (b != 8'h00) mark_error(ST_BAD_START);
				else parse_phase = PH_SC2;
			end
			PH_SC2: begin
				if (b == SC_ONE) parse_phase = PH_HDR0;
				else if (b == 8'h00) parse_phase = PH_SC3;
				else mark_error(ST_BAD_START);
			end
			PH_SC3: begin
				if (b == SC_ONE) parse_phase = PH_HDR0;
				else mark_error(ST_BAD_START);
			end
			PH_HDR0: begin
				held        = b;
				parse_phase = PH_HDR1;
			end
			PH_HDR1: begin
				nal_type = 5'((held & TYPE_MASK) >> 1);
				if ((held & HDR_MASK) != HDR_MATCH || b != RSVD_BYTE) begin
					mark_error(ST_BAD_BITS);
				end else if (nal_type != TYPE_NON_IDR && nal_type != TYPE_IDR) begin
					mark_error(ST_BAD_TYPE);
				end else begin
					idr         = (nal_type == TYPE_IDR);
					held        = 8'h00;
					held_ok     = 1'b0;
					zero_run    = 2'd0;
					parse_phase = PH_BODY;
				end
			end
			PH_BODY: begin
				if (zero_run == 2'd2 && b == EPB_BYTE) begin
					zero_run = 2'd0;
				end else begin
					if (b == 8'h00) zero_run = (zero_run == 2'd3) ? 2'd3 : zero_run + 2'd1;
					else zero_run = 2'd0;
					if (held_ok) begin
						w.data    = held;
						w.data_ok = 1'b1;
						count_payload();
						expected_words.push_back(w);
					end
					held    = b;
					held_ok = 1'b1;
				end
			end
			default: ;
			endcase
		end else begin
			if (parse_phase == PH_SINK) begin
				w.st = (b != STOP_BYTE) ? ST_NO_STOP : err_code;
			end else if (parse_phase == PH_BODY) begin
				if (held_ok) begin
					w.data    = held;
					w.data_ok = 1'b1;
					count_payload();
				end
				w.st = (b != STOP_BYTE) ? ST_NO_STOP : ST_OK;
			end else begin
				w.st = ST_SHORT;
			end
			w.done = 1'b1;
			w.idr  = idr;
			w.len  = emitted[LEN_OUT_W-1:0];
			expected_words.push_back(w);
			clear_parser();
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		strip_word_t w;
		if (!arst_n) begin
			clear_parser();
			expected_words.delete();
			mismatches = 0;
		end else begin
			if (res_valid && !res_stall) begin
				if (expected_words.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("%0t: unexpected word: byte %h/%b done %b status %0d idr %b len %0d",
							$realtime, out_byte, out_valid, unit_done, status, is_idr,
							payload_length);
				end else begin
					w = expected_words.pop_front();
					if (out_byte !== w.data || out_valid !== w.data_ok || unit_done !== w.done ||
							status !== w.st || is_idr !== w.idr || payload_length !== w.len) begin
						mismatches++;
						if (mismatches <= 10)
							$display({"%0t: mismatch: expected byte %h/%b done %b status %0d idr %b ",
								"len %0d, got byte %h/%b done %b status %0d idr %b len %0d"},
								$realtime, w.data, w.data_ok, w.done, w.st, w.idr, w.len,
								out_byte, out_valid, unit_done, status, is_idr, payload_length);
					end
				end
			end
			if (in_valid && !in_stall)
				predict_unwrap(in_byte, end_of_unit);
		end
		outstanding = expected_words.size();
	end

endmodule

>>> sim/nal_unit_emulation_strip_test.sv
`timescale 1ns / 100ps

module nal_unit_emulation_strip_test;
	import nues_pkg::*;

	localparam int WORDS_TARGET   = 1200;  // input words over the whole run
	localparam int WATCHDOG_LIMIT = 2000;  // cycles with no word moving on either side
	localparam int DRAIN_CYCLES   = 8;

	logic                 clk         = 1'b0;
	logic                 arst_n      = 1'b0;
	logic                 in_valid    = 1'b0;
	logic [7:0]           in_byte     = 8'h00;
	logic                 end_of_unit = 1'b0;
	logic                 res_stall   = 1'b0;
	logic                 in_stall;
	logic                 res_valid;
	logic [7:0]           out_byte;
	logic                 out_valid;
	logic                 unit_done;
	logic [2:0]           status;
	logic                 is_idr;
	logic [LEN_OUT_W-1:0] payload_length;

	int   mismatches;
	int   outstanding;
	int   words_sent  = 0;
	int   idle_cycles = 0;
	bit   quiet       = 1'b0; // suppress all idling on both sides while set
	logic [7:0] unit_q[$];    // bytes of the unit being built, sent in order

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	nal_unit_emulation_strip dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.in_byte        (in_byte),
		.end_of_unit    (end_of_unit),
		.res_valid      (res_valid),
		.res_stall      (res_stall),
		.out_byte       (out_byte),
		.out_valid      (out_valid),
		.unit_done      (unit_done),
		.status         (status),
		.is_idr         (is_idr),
		.payload_length (payload_length)
	);

	nal_unit_emulation_strip_check check (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.in_byte        (in_byte),
		.end_of_unit    (end_of_unit),
		.res_valid      (res_valid),
		.res_stall      (res_stall),
		.out_byte       (out_byte),
		.out_valid      (out_valid),
		.unit_done      (unit_done),
		.status         (status),
		.is_idr         (is_idr),
		.payload_length (payload_length),
		.mismatches     (mismatches),
		.outstanding    (outstanding)
	);

	// Hold off result words now and then, except during the quiet stretch.
	always @(posedge clk) begin
		res_stall <= !quiet && ($urandom_range(99) < 6);
	end

	// End the run if no word moves on either channel for too long.
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (res_valid && !res_stall))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("nal_unit_emulation_strip_test NOT OK");
			$finish;
		end
	end

	// Offer one word and hold it until the block takes it. Idle first at random,
	// so gaps land between any two bytes of a unit.
	task automatic put_word(input logic [7:0] b, input logic last);
		while (!quiet && $urandom_range(99) < 6) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid    <= 1'b1;
		in_byte     <= b;
		end_of_unit <= last;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		words_sent++;
	endtask

	// Send the built unit, flag its last byte, and empty the build queue.
	task automatic send_unit();
		foreach (unit_q[i])
			put_word(unit_q[i], i == unit_q.size() - 1);
		unit_q.delete();
	endtask

	// Append a start code (three or four bytes) and a well-formed header.
	task automatic add_prefix(input bit four_byte_sc, input bit idr);
		unit_q.push_back(8'h00);
		unit_q.push_back(8'h00);
		if (four_byte_sc)
			unit_q.push_back(8'h00);
		unit_q.push_back(SC_ONE);
		unit_q.push_back(HDR_MATCH | {2'b00, idr ? TYPE_IDR : TYPE_NON_IDR, 1'b0});
		unit_q.push_back(RSVD_BYTE);
	endtask

	// Body bytes lean on zeros and 0x03 so that emulation prevention patterns,
	// long zero runs and kept 0x03 bytes come up often.
	function automatic logic [7:0] body_byte();
		int r;
		r = $urandom_range(99);
		if (r < 35) return 8'h00;
		if (r < 55) return EPB_BYTE;
		if (r < 62) return SC_ONE;
		return 8'($urandom_range(255));
	endfunction

	// Build and send one random unit: mostly well-formed with random content,
	// the rest corrupted prefixes, truncated units and raw noise.
	task automatic random_unit();
		int kind;
		int n;
		int k;
		bit four;
		kind = $urandom_range(99);
		four = 1'($urandom_range(1));
		if (kind < 80) begin
			add_prefix(four, 1'($urandom_range(1)));
			n = ($urandom_range(19) == 0) ? $urandom_range(200) : $urandom_range(24);
			repeat (n)
				unit_q.push_back(body_byte());
			// Corrupt one byte of the start code or header.
			if (kind >= 70) begin
				k = $urandom_range(four ? 5 : 4);
				unit_q[k] = 8'($urandom_range(255));
			end
			unit_q.push_back(($urandom_range(99) < 92) ? STOP_BYTE : 8'($urandom_range(255)));
		end else if (kind < 90) begin
			// Cut the unit off before the header is complete.
			add_prefix(four, 1'($urandom_range(1)));
			k = $urandom_range(four ? 5 : 4);
			while (unit_q.size() > k)
				void'(unit_q.pop_back());
			unit_q.push_back($urandom_range(1) ? STOP_BYTE : 8'($urandom_range(255)));
		end else begin
			n = $urandom_range(1, 8);
			repeat (n)
				unit_q.push_back($urandom_range(1) ? 8'h00 : 8'($urandom_range(255)));
			unit_q.push_back($urandom_range(1) ? STOP_BYTE : 8'($urandom_range(255)));
		end
		send_unit();
	endtask

	initial begin
		repeat (11)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Shortest good unit: header, no payload, stop byte.
		add_prefix(1'b0, 1'b0);
		unit_q.push_back(STOP_BYTE);
		send_unit();

		// IDR unit: drop 0x03 after two zeros, keep it after three, and drop one
		// right before the trailing zeros.
		add_prefix(1'b1, 1'b1);
		unit_q = {unit_q, 8'h00, 8'h00, EPB_BYTE, 8'hFF, 8'h00, 8'h00, 8'h00, EPB_BYTE,
			8'h00, 8'h00, EPB_BYTE, 8'h00, 8'h00, STOP_BYTE};
		send_unit();

		// Missing stop byte after a good header: the held byte still leaves.
		add_prefix(1'b0, 1'b1);
		unit_q = {unit_q, 8'hAA, 8'h7F};
		send_unit();

		// Bad start code, then the rest is ignored.
		unit_q = {8'h00, 8'h05, 8'h00, 8'h00, SC_ONE, STOP_BYTE};
		send_unit();

		// Four zeros where the start code wants 0x01.
		unit_q = {8'h00, 8'h00, 8'h00, 8'h00, SC_ONE, 8'h79, RSVD_BYTE, STOP_BYTE};
		send_unit();

		// Forbidden bits set in the first header byte.
		unit_q = {8'h00, 8'h00, SC_ONE, 8'hF9, RSVD_BYTE, STOP_BYTE};
		send_unit();

		// Wrong reserved byte and no stop byte: the stop check wins.
		unit_q = {8'h00, 8'h00, SC_ONE, 8'h79, 8'hFE, 8'h11, 8'h00};
		send_unit();

		// Type outside the enhancement-layer pair.
		unit_q = {8'h00, 8'h00, 8'h00, SC_ONE, HDR_MATCH, RSVD_BYTE, STOP_BYTE};
		send_unit();

		// Too short: a lone final byte, and a unit ending inside the header.
		unit_q = {STOP_BYTE};
		send_unit();
		unit_q = {8'h00, 8'h00, SC_ONE, 8'h79, STOP_BYTE};
		send_unit();

		// Random units, with a stretch in the middle where neither side idles.
		while (words_sent < WORDS_TARGET) begin
			quiet = (words_sent >= 400 && words_sent < 700);
			random_unit();
		end
		quiet = 1'b0;
		in_valid <= 1'b0;

		// Drain every expected word, then give the block a few more cycles.
		do
			@(posedge clk);
		while (outstanding != 0);
		repeat (DRAIN_CYCLES)
			@(posedge clk);

		if (mismatches == 0 && outstanding == 0)
			$display("nal_unit_emulation_strip_test OK");
		else
			$display("nal_unit_emulation_strip_test NOT OK");
		$finish;
	end

endmodule

>>> sim.f
rtl/nues_pkg.sv
rtl/nues_step.sv
rtl/nal_unit_emulation_strip.sv
sim/nal_unit_emulation_strip_check.sv
sim/nal_unit_emulation_strip_test.sv
